// ===== design/qss_pkg.sv =====
// Shared types and codes for the quicksort sequence sorter.
package qss_pkg;

  typedef struct packed {
    logic signed [31:0] value;
    logic               last_item;
  } item_t;

  typedef struct packed {
    logic signed [31:0] sorted_value;
    logic               last_result;
    logic               overflow;
  } result_t;

  typedef enum logic [3:0] {
    S_LOAD,
    S_START,
    S_POP,
    S_LATCH,
    S_PIV,
    S_RD,
    S_CMP,
    S_SWP,
    S_FRD,
    S_FW1,
    S_FW2,
    S_PSH1,
    S_PSH2,
    S_ORD,
    S_OUT
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_START,
    OP_POP,
    OP_LATCH,
    OP_PIV,
    OP_RD,
    OP_SWAP1,
    OP_STEP,
    OP_SWAP2,
    OP_FRD,
    OP_FW1,
    OP_FW2,
    OP_PSH1,
    OP_PSH2,
    OP_ORD,
    OP_EMIT
  } op_t;

  typedef struct packed {
    logic count_small;
    logic sp_zero;
    logic less;
    logic fast_end;
    logic out_end;
  } status_t;

endpackage

// ===== design/qss_ctrl.sv =====
// Controller state machine for the quicksort sequence sorter.
module qss_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  input  logic             last_item,
  input  logic             result_stall,
  input  qss_pkg::status_t status,
  output qss_pkg::op_t     op,
  output logic             item_stall,
  output logic             result_valid
);
  import qss_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    op           = OP_NONE;
    item_stall   = 1'b1;
    result_valid = 1'b0;
    case (state)
      S_LOAD: begin
        item_stall = 1'b0;
        if (item_valid) begin
          op = OP_LOAD;
          if (last_item) begin
            state_next = S_START;
          end
        end
      end
      S_START: begin
        if (status.count_small) begin
          state_next = S_ORD;
        end else begin
          op         = OP_START;
          state_next = S_POP;
        end
      end
      S_POP: begin
        if (status.sp_zero) begin
          state_next = S_ORD;
        end else begin
          op         = OP_POP;
          state_next = S_LATCH;
        end
      end
      S_LATCH: begin
        op         = OP_LATCH;
        state_next = S_PIV;
      end
      S_PIV: begin
        op         = OP_PIV;
        state_next = S_RD;
      end
      S_RD: begin
        op         = OP_RD;
        state_next = S_CMP;
      end
      S_CMP: begin
        if (status.less) begin
          op         = OP_SWAP1;
          state_next = S_SWP;
        end else begin
          op         = OP_STEP;
          state_next = status.fast_end ? S_FRD : S_RD;
        end
      end
      S_SWP: begin
        op         = OP_SWAP2;
        state_next = status.fast_end ? S_FRD : S_RD;
      end
      S_FRD: begin
        op         = OP_FRD;
        state_next = S_FW1;
      end
      S_FW1: begin
        op         = OP_FW1;
        state_next = S_FW2;
      end
      S_FW2: begin
        op         = OP_FW2;
        state_next = S_PSH1;
      end
      S_PSH1: begin
        op         = OP_PSH1;
        state_next = S_PSH2;
      end
      S_PSH2: begin
        op         = OP_PSH2;
        state_next = S_POP;
      end
      S_ORD: begin
        op         = OP_ORD;
        state_next = S_OUT;
      end
      S_OUT: begin
        result_valid = 1'b1;
        if (!result_stall) begin
          op         = OP_EMIT;
          state_next = status.out_end ? S_LOAD : S_ORD;
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

endmodule

// ===== design/qss_dp.sv =====
// Datapath for the quicksort sequence sorter: element store, range stack, indices.
module qss_dp #(
  parameter int DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  qss_pkg::op_t       op,
  input  logic signed [31:0] value,
  output qss_pkg::status_t   status,
  output qss_pkg::result_t   result
);
  import qss_pkg::*;

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic signed [31:0] store [DEPTH];
  logic [2*IW-1:0]    stack [DEPTH];

  logic signed [31:0] rd_a;
  logic signed [31:0] rd_b;
  logic [2*IW-1:0]    st_rd;

  logic [CW-1:0]      count;
  logic               dropped;
  logic [CW-1:0]      sp;
  logic [IW-1:0]      lo;
  logic [IW-1:0]      hi;
  logic [IW-1:0]      slow;
  logic [IW-1:0]      fast;
  logic [IW-1:0]      k;
  logic signed [31:0] pivot;

  logic               wr_en;
  logic [IW-1:0]      wr_addr;
  logic signed [31:0] wr_data;
  logic               ra_en;
  logic [IW-1:0]      ra_addr;
  logic               rb_en;
  logic [IW-1:0]      rb_addr;
  logic               sw_en;
  logic [IW-1:0]      sw_addr;
  logic [2*IW-1:0]    sw_data;
  logic               sr_en;
  logic [IW-1:0]      sr_addr;

  logic               not_full;
  logic               sp_room;
  logic               push_left;
  logic               push_right;

  assign not_full   = count < CW'(DEPTH);
  assign sp_room    = sp < CW'(DEPTH);
  assign push_left  = {1'b0, slow} > ({1'b0, lo} + (IW+1)'(1));
  assign push_right = ({1'b0, slow} + (IW+1)'(1)) < {1'b0, hi};

  assign status.count_small = count < CW'(2);
  assign status.sp_zero     = sp == '0;
  assign status.less        = rd_a < pivot;
  assign status.fast_end    = fast == hi;
  assign status.out_end     = CW'(k) == (count - CW'(1));

  assign result.sorted_value = rd_a;
  assign result.last_result  = status.out_end;
  assign result.overflow     = dropped;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    ra_en   = 1'b0;
    ra_addr = '0;
    rb_en   = 1'b0;
    rb_addr = '0;
    sw_en   = 1'b0;
    sw_addr = '0;
    sw_data = '0;
    sr_en   = 1'b0;
    sr_addr = '0;
    case (op)
      OP_LOAD: begin
        wr_en   = not_full;
        wr_addr = IW'(count);
        wr_data = value;
      end
      OP_START: begin
        sw_en   = 1'b1;
        sw_addr = '0;
        sw_data = {IW'(0), IW'(count - CW'(1))};
      end
      OP_POP: begin
        sr_en   = 1'b1;
        sr_addr = IW'(sp - CW'(1));
      end
      OP_LATCH: begin
        ra_en   = 1'b1;
        ra_addr = st_rd[2*IW-1:IW];
      end
      OP_RD: begin
        ra_en   = 1'b1;
        ra_addr = fast;
        rb_en   = 1'b1;
        rb_addr = slow + IW'(1);
      end
      OP_SWAP1: begin
        wr_en   = 1'b1;
        wr_addr = slow + IW'(1);
        wr_data = rd_a;
      end
      OP_SWAP2: begin
        wr_en   = 1'b1;
        wr_addr = fast;
        wr_data = rd_b;
      end
      OP_FRD: begin
        ra_en   = 1'b1;
        ra_addr = slow;
      end
      OP_FW1: begin
        wr_en   = 1'b1;
        wr_addr = lo;
        wr_data = rd_a;
      end
      OP_FW2: begin
        wr_en   = 1'b1;
        wr_addr = slow;
        wr_data = pivot;
      end
      OP_PSH1: begin
        sw_en   = push_left && sp_room;
        sw_addr = IW'(sp);
        sw_data = {lo, slow - IW'(1)};
      end
      OP_PSH2: begin
        sw_en   = push_right && sp_room;
        sw_addr = IW'(sp);
        sw_data = {slow + IW'(1), hi};
      end
      OP_ORD: begin
        ra_en   = 1'b1;
        ra_addr = k;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wr_addr] <= wr_data;
    end
    if (ra_en) begin
      rd_a <= store[ra_addr];
    end
    if (rb_en) begin
      rd_b <= store[rb_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (sw_en) begin
      stack[sw_addr] <= sw_data;
    end
    if (sr_en) begin
      st_rd <= stack[sr_addr];
    end
  end

  always_ff @(posedge clk) begin
    case (op)
      OP_LATCH: begin
        lo <= st_rd[2*IW-1:IW];
        hi <= st_rd[IW-1:0];
      end
      OP_PIV: begin
        pivot <= rd_a;
        slow  <= lo;
        fast  <= lo + IW'(1);
      end
      OP_SWAP1: begin
        slow <= slow + IW'(1);
      end
      OP_STEP, OP_SWAP2: begin
        fast <= fast + IW'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      dropped <= 1'b0;
      sp      <= '0;
      k       <= '0;
    end else begin
      case (op)
        OP_LOAD: begin
          if (not_full) begin
            count <= count + CW'(1);
          end else begin
            dropped <= 1'b1;
          end
        end
        OP_START: begin
          sp <= CW'(1);
        end
        OP_POP: begin
          sp <= sp - CW'(1);
        end
        OP_PSH1: begin
          if (push_left && sp_room) begin
            sp <= sp + CW'(1);
          end
        end
        OP_PSH2: begin
          if (push_right && sp_room) begin
            sp <= sp + CW'(1);
          end
        end
        OP_EMIT: begin
          if (status.out_end) begin
            k       <= '0;
            count   <= '0;
            dropped <= 1'b0;
          end else begin
            k <= k + IW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== design/quicksort_sequence_sorter_core.sv =====
// Quicksort sequence sorter: loads values, sorts in place, emits them ascending.
// Load: one beat per cycle while idle; a beat flagged last starts the sort.
// Sort: ranges are taken from the range stack and partitioned one at a time; each swap
//   takes two writes, as the element store has a single write port.
// Emit: each result beat is a store read, then output; output stalls hold it.
// Reset clears counters, stack pointer and overflow; store contents stay undefined.
module quicksort_sequence_sorter_core #(
  parameter int DEPTH = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  qss_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_stall,
  output qss_pkg::result_t result
);
  import qss_pkg::*;

  op_t     op;
  status_t status;

  qss_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .last_item    (item.last_item),
    .result_stall (result_stall),
    .status       (status),
    .op           (op),
    .item_stall   (item_stall),
    .result_valid (result_valid)
  );

  qss_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .op     (op),
    .value  (item.value),
    .status (status),
    .result (result)
  );

  a_stop_after_last: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall && item.last_item |=> item_stall)
    else $error("input taken after the last beat of a sequence");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(result_valid && !item_stall))
    else $error("input open while a result beat is pending");

  a_reopen_after_burst: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_stall && result.last_result |=> !item_stall && !result_valid)
    else $error("block did not return to loading after the final result");

endmodule
